/* src/mpe_pkg.sv */
package mpe_pkg;

    localparam int DATA_W    = 32;
    localparam int POW_W     = 4;
    localparam int MAX_POWER = 15;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_VALUE = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MUL   = 3'b010,
        ST_ACCUM = 3'b100
    } state_t;

    // limit an exponent to the largest supported power
    function automatic logic [POW_W-1:0] clamp_pow(input logic [POW_W-1:0] p);
        logic [POW_W-1:0] r;
        if (int'(p) > MAX_POWER)
        begin
            r = POW_W'(MAX_POWER);
        end
        else
        begin
            r = p;
        end
        return r;
    endfunction

endpackage

/* src/mpe_mul.sv */
module mpe_mul
    import mpe_pkg::*;
(
    input  logic [DATA_W-1:0] op_a,
    input  logic [DATA_W-1:0] op_b,
    output logic [DATA_W-1:0] product
);

    logic [2*DATA_W-1:0] full_product;

    // unsigned product, low word equals the two's complement wrapped product
    assign full_product = {{DATA_W{1'b0}}, op_a} * {{DATA_W{1'b0}}, op_b};
    assign product      = full_product[DATA_W-1:0];

endmodule

/* src/multivariate_poly_eval.sv */
// Three-variable polynomial evaluator. Set the point (x, y, z) through the
// cfg port (index 0 = x, 1 = y, 2 = z) while the block is idle. Each input
// transfer is one term: coefficient, power_x, power_y and power_z in
// s_axis_tdata and the last-term mark in s_axis_tlast. The term
// coefficient * x^power_x * y^power_y * z^power_z is built by one shared
// 32x32 multiplier, one multiply per cycle, and added to a 32-bit running
// sum with two's complement wrap. A term is taken, then multiplied once per
// exponent step, then the multiply pass closes, then the term is added.
// s_axis_tready is low after the take until the add is done. On the last term
// the sum goes out as one transfer on m_axis and the running sum clears.
// The output register lets the next term be taken while a result still
// waits; a last term holds in the add step while an earlier sum still waits.
module multivariate_poly_eval
    import mpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    // term input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // coefficient[31:0], power_x[35:32], power_y[39:36], power_z[43:40], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // poly_sum[31:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] x_reg, y_reg, z_reg;
    logic [DATA_W-1:0] term_reg, term_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [POW_W-1:0]  cnt_x_reg, cnt_x_next;
    logic [POW_W-1:0]  cnt_y_reg, cnt_y_next;
    logic [POW_W-1:0]  cnt_z_reg, cnt_z_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [DATA_W-1:0] mul_base;
    logic [DATA_W-1:0] mul_product;
    logic [DATA_W-1:0] acc_total;
    logic              in_xfer;
    logic              out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign acc_total     = sum_reg + term_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_VALUE: x_reg <= cfg_data;
                REG_Y_VALUE: y_reg <= cfg_data;
                REG_Z_VALUE: z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // base picked by the remaining exponent counts
    always_comb
    begin
        priority if (cnt_x_reg != '0)
        begin
            mul_base = x_reg;
        end
        else if (cnt_y_reg != '0)
        begin
            mul_base = y_reg;
        end
        else
        begin
            mul_base = z_reg;
        end
    end

    // shared multiplier
    mpe_mul u_mul (
        .op_a    (term_reg),
        .op_b    (mul_base),
        .product (mul_product)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        cnt_x_next     = cnt_x_reg;
        cnt_y_next     = cnt_y_reg;
        cnt_z_next     = cnt_z_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    term_next  = s_axis_tdata[DATA_W-1:0];
                    cnt_x_next = clamp_pow(s_axis_tdata[DATA_W +: POW_W]);
                    cnt_y_next = clamp_pow(s_axis_tdata[DATA_W+POW_W +: POW_W]);
                    cnt_z_next = clamp_pow(s_axis_tdata[DATA_W+2*POW_W +: POW_W]);
                    last_next  = s_axis_tlast;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                priority if (cnt_x_reg != '0)
                begin
                    term_next  = mul_product;
                    cnt_x_next = cnt_x_reg - 1'b1;
                end
                else if (cnt_y_reg != '0)
                begin
                    term_next  = mul_product;
                    cnt_y_next = cnt_y_reg - 1'b1;
                end
                else if (cnt_z_reg != '0)
                begin
                    term_next  = mul_product;
                    cnt_z_next = cnt_z_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (!last_reg)
                begin
                    sum_next   = acc_total;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_data_next  = acc_total;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        term_reg     <= term_next;
        cnt_x_reg    <= cnt_x_next;
        cnt_y_reg    <= cnt_y_next;
        cnt_z_reg    <= cnt_z_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* verif/tb_multivariate_poly_eval.sv */
module tb_multivariate_poly_eval;
    import mpe_pkg::*;

    // cycles allowed after the last result before the point may change
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 500000;
    // index past the register list, writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] coefficient;
        logic [POW_W-1:0]         power_x;
        logic [POW_W-1:0]         power_y;
        logic [POW_W-1:0]         power_z;
        logic                     last_term;
    } term_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow of the evaluation point and the running sum
    logic [DATA_W-1:0] point_x = '0;
    logic [DATA_W-1:0] point_y = '0;
    logic [DATA_W-1:0] point_z = '0;
    logic [DATA_W-1:0] partial_sum = '0;
    logic [DATA_W-1:0] expected_sums[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  steady_source = 1'b0;
    bit  steady_sink = 1'b0;

    multivariate_poly_eval dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // base^e wrapped to 32 bits, exponent limited to the largest power
    function automatic logic [DATA_W-1:0] power_of(input logic [DATA_W-1:0] base,
                                                   input logic [POW_W-1:0] e);
        logic [DATA_W-1:0] acc;
        int                n;
        acc = 1;
        n = (int'(e) > MAX_POWER) ? MAX_POWER : int'(e);
        for (int i = 0; i < n; i++)
        begin
            acc = acc * base;
        end
        return acc;
    endfunction

    function automatic logic [DATA_W-1:0] term_product(input term_t t);
        logic [DATA_W-1:0] p;
        p = t.coefficient;
        p = p * power_of(point_x, t.power_x);
        p = p * power_of(point_y, t.power_y);
        p = p * power_of(point_z, t.power_z);
        return p;
    endfunction

    // ---------------------------------------------------------------
    // random helpers
    // ---------------------------------------------------------------

    // mostly none or short, now and then long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // point coordinates lean small so high powers do not collapse to zero
    function automatic logic [DATA_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return DATA_W'($signed($urandom_range(0, 8)) - 4);
        else if (r < 65)
            return pick_extreme();
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_coefficient();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        else if (r < 80)
            return DATA_W'($signed($urandom_range(0, 200)) - 100);
        return pick_extreme();
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_VALUE: point_x = value;
            REG_Y_VALUE: point_y = value;
            REG_Z_VALUE: point_z = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one term transfer; valid stays high afterwards unless a gap follows
    task automatic send_term(input term_t t);
        int gap;
        gap = steady_source ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - DATA_W - 3*POW_W){1'b0}},
                          t.power_z, t.power_y, t.power_x, t.coefficient};
        s_axis_tlast  <= t.last_term;
        do
            @(posedge clk);
        while (!s_axis_tready);
        partial_sum = partial_sum + term_product(t);
        if (t.last_term)
        begin
            expected_sums.push_back(partial_sum);
            partial_sum = '0;
        end
    endtask

    task automatic send(input logic [DATA_W-1:0] coef, input int px, input int py,
                        input int pz, input bit last);
        send_term('{coef, POW_W'(px), POW_W'(py), POW_W'(pz), last});
    endtask

    // stop feeding terms until every pending sum has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // block fully idle, safe for register writes
    task automatic drain_and_settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result sink back-pressure
    initial
    begin
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!steady_sink && $urandom_range(0, 1))
            begin
                m_axis_tready <= 1'b0;
                repeat (1 + idle_cycles()) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // result check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("poly_sum unexpected: got %0d with nothing pending",
                       $signed(m_axis_tdata));
                mismatch_count++;
            end
            else
            begin
                logic [DATA_W-1:0] want;
                want = expected_sums.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("poly_sum mismatch: expected %0d, got %0d",
                           $signed(want), $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // point is zero after reset: only all-zero-power terms count
    task automatic test_reset_point();
        send(32'd5, 0, 0, 0, 1'b0);
        send(32'd123, 3, 0, 0, 1'b0);
        send(-32'sd9, 0, 0, 15, 1'b1);
        send(32'h7FFF_FFFF, 0, 0, 0, 1'b1);
        drain_and_settle();
    endtask

    // each register lands in its own variable, unused index is dropped
    task automatic test_register_writes();
        write_reg(REG_X_VALUE, 32'd3);
        write_reg(REG_Y_VALUE, 32'd5);
        write_reg(REG_Z_VALUE, 32'd7);
        write_reg(REG_UNUSED, $urandom);
        send(32'd1, 1, 0, 0, 1'b1);
        send(32'd1, 0, 1, 0, 1'b1);
        send(32'd1, 0, 0, 1, 1'b1);
        send(32'd2, 2, 2, 2, 1'b1);
        drain_and_settle();
    endtask

    // extreme point and coefficients, maximum powers, wrapping sums
    task automatic test_extremes();
        write_reg(REG_X_VALUE, 32'hFFFF_FFFF);
        write_reg(REG_Y_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_Z_VALUE, 32'h8000_0000);
        send(32'h8000_0000, 15, 0, 0, 1'b1);
        send(32'h7FFF_FFFF, 0, 15, 0, 1'b1);
        send(32'd1, 0, 0, 1, 1'b1);
        send(32'd1, 0, 0, 15, 1'b1);
        send(32'h7FFF_FFFF, 0, 0, 0, 1'b0);
        send(32'h7FFF_FFFF, 0, 0, 0, 1'b1);
        send(32'hFFFF_FFFF, 15, 15, 15, 1'b1);
        drain_and_settle();
        write_reg(REG_X_VALUE, 32'd2);
        write_reg(REG_Y_VALUE, 32'hFFFF_FFFD);
        write_reg(REG_Z_VALUE, 32'd0);
        send(32'hFFFF_FFFF, 15, 15, 0, 1'b0);
        send(32'd9, 14, 1, 0, 1'b0);
        send(32'd4, 0, 0, 1, 1'b0);
        send(32'd6, 8, 8, 0, 1'b1);
        drain_and_settle();
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        steady_source = 1'b1;
        steady_sink = 1'b1;
        write_reg(REG_X_VALUE, pick_coord());
        write_reg(REG_Y_VALUE, pick_coord());
        write_reg(REG_Z_VALUE, pick_coord());
        for (int i = 0; i < 40; i++)
        begin
            send(pick_coefficient(), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), ($urandom_range(0, 2) == 0) || (i == 39));
        end
        drain_and_settle();
        steady_source = 1'b0;
        steady_sink = 1'b0;
    endtask

    // random polynomials over a sequence of random points
    task automatic test_random_polys(input int num_terms);
        int sent;
        int phase_end;
        int len;
        sent = 0;
        while (sent < num_terms)
        begin
            drain_and_settle();
            case ($urandom_range(0, 2))
                0:
                begin
                    write_reg(REG_X_VALUE, pick_coord());
                    write_reg(REG_Y_VALUE, pick_coord());
                    write_reg(REG_Z_VALUE, pick_coord());
                end
                1:
                begin
                    write_reg(REG_Z_VALUE, pick_coord());
                    write_reg(REG_UNUSED, $urandom);
                    write_reg(REG_X_VALUE, pick_coord());
                end
                default:
                begin
                    write_reg(REG_Y_VALUE, pick_coord());
                end
            endcase
            phase_end = sent + $urandom_range(30, 90);
            while (sent < phase_end && sent < num_terms)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    send(pick_coefficient(), $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15), k == len - 1);
                end
                sent += len;
                if ($urandom_range(0, 14) == 0)
                    hold_until_drained();
            end
        end
        drain_and_settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_point();
        test_register_writes();
        test_extremes();
        test_back_to_back();
        test_random_polys(800);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
